FILE: sv/median_filter_3x3_stream_core_assert.svh
// Assertion macros for the 3x3 median filter core
`ifndef MEDIAN_FILTER_3X3_STREAM_CORE_ASSERT_SVH
`define MEDIAN_FILTER_3X3_STREAM_CORE_ASSERT_SVH
// implication checked every cycle outside reset
`define MF_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// implication checked on the following cycle
`define MF_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

FILE: sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants for the 3x3 median filter core.
// ----------------------------------------------------------------------------
package mf3_pkg;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int CH_W = 8;
    localparam int PIX_W = 24;
    localparam int WIN_TAPS = 9;
    localparam int MID_TAP = 4;
    localparam int CRD_W = 11;
    localparam int CFG_W = 12;
    localparam int MAX_HEIGHT = 2048;
    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    typedef logic [CH_W-1:0] t_chan;
    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix       pix;
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
        logic       filt;
        logic       last;
    } t_res;
endpackage

FILE: sv/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

FILE: sv/mf3_lane.sv
// ----------------------------------------------------------------------------
// mf3_lane
// Median of nine 8-bit values for one channel, two register stages.
// ----------------------------------------------------------------------------
module mf3_lane
    import mf3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  mf3_pkg::t_chan [8:0] i_taps,
    output mf3_pkg::t_chan       o_med
);
    t_chan r_lo [3];
    t_chan r_md [3];
    t_chan r_hi [3];
    t_chan n_lo [3];
    t_chan n_md [3];
    t_chan n_hi [3];
    t_chan r_med;
    t_chan mx_lo, mn_hi, md_md;

    function automatic t_chan mx(input t_chan a, input t_chan b);
        mx = (a > b) ? a : b;
    endfunction
    function automatic t_chan mn(input t_chan a, input t_chan b);
        mn = (a < b) ? a : b;
    endfunction
    function automatic t_chan med3(input t_chan a, input t_chan b, input t_chan c);
        med3 = mx(mn(a, b), mn(mx(a, b), c));
    endfunction

    // sort each column of three
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = mn(mn(i_taps[3*k], i_taps[3*k+1]), i_taps[3*k+2]);
            n_hi[k] = mx(mx(i_taps[3*k], i_taps[3*k+1]), i_taps[3*k+2]);
            n_md[k] = med3(i_taps[3*k], i_taps[3*k+1], i_taps[3*k+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_md <= n_md;
            r_hi <= n_hi;
        end
    end

    // median = med3(max of lows, med of mids, min of highs)
    assign mx_lo = mx(mx(r_lo[0], r_lo[1]), r_lo[2]);
    assign mn_hi = mn(mn(r_hi[0], r_hi[1]), r_hi[2]);
    assign md_md = med3(r_md[0], r_md[1], r_md[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_med <= med3(mx_lo, md_md, mn_hi);
        end
    end
    assign o_med = r_med;
endmodule

FILE: sv/mf3_outq.sv
// ----------------------------------------------------------------------------
// mf3_outq
// Result queue; absorbs the row-end bursts of up to three results.
// ----------------------------------------------------------------------------
module mf3_outq
    import mf3_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_push,
    input  mf3_pkg::t_res i_d0,
    input  mf3_pkg::t_res i_d1,
    input  mf3_pkg::t_res i_d2,
    output logic          o_valid,
    input  logic          i_ready,
    output mf3_pkg::t_res o_q,
    output logic [$clog2(DEPTH):0] o_count
);
    localparam int AW = $clog2(DEPTH);
    t_res r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp;
    logic [AW:0]   r_cnt;
    logic          pop;
    logic [1:0]    npush;

    assign pop = o_valid && i_ready;
    assign npush = 2'(i_push[0]) + 2'(i_push[1]) + 2'(i_push[2]);
    assign n_wp = r_wp + AW'(npush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(npush) - (AW+1)'(pop);
        end
    end

    // entries arrive packed: slot 0, 1, 2 are contiguous
    always_ff @(posedge i_clk) begin
        if (i_push[0]) r_mem[r_wp] <= i_d0;
        if (i_push[1]) r_mem[AW'(r_wp + 1'b1)] <= i_d1;
        if (i_push[2]) r_mem[AW'(r_wp + 2'd2)] <= i_d2;
    end

    assign o_valid = (r_cnt != '0);
    assign o_q = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

FILE: sv/median_filter_3x3_stream_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_core
// 3x3 median filter over a raster pixel stream with border pass-through.
// Pipeline: stage-1 registers, lane and side registers of stages 2 and 3,
// then the output queue, which is read straight out with no extra stage.
// Throughput: one item a cycle while the queue has room; a row end releases
// up to three results, drained from the queue at one a cycle while i_ready is high.
// Reset: synchronous active-low; clears counts, window and queue and loads
// width 640, height 480, true-colour mode. Line stores are not cleared.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_core
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [CHANNEL_BITS-1:0] i_pix_blue,
    input  logic [CHANNEL_BITS-1:0] i_pix_green,
    input  logic [CHANNEL_BITS-1:0] i_pix_red,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0] i_cfg_data,
    output logic o_valid,
    input  logic i_ready,
    output logic [CHANNEL_BITS-1:0] o_out_blue,
    output logic [CHANNEL_BITS-1:0] o_out_green,
    output logic [CHANNEL_BITS-1:0] o_out_red,
    output logic [mf3_pkg::CRD_W-1:0] o_out_col,
    output logic [mf3_pkg::CRD_W-1:0] o_out_row,
    output logic o_was_filtered,
    output logic o_last_of_run
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QD = 16;
    // the accepted item and the three ahead of it in the pipeline release at
    // most nine results between them
    localparam int QLIM = QD - 9;
    // largest width the register can ask for, capped by the line store depth
    localparam int W_LIM = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;

    // ---- configuration ----
    logic [CFG_W-1:0] r_width, r_height;
    logic             r_tc;
    logic [CFG_W:0]   w_eff, h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_W'(640);
            r_height <= CFG_W'(480);
            r_tc <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_MODE:   r_tc <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate to the supported frame size
    always_comb begin
        w_eff = {1'b0, r_width};
        if (r_width < CFG_W'(3)) w_eff = (CFG_W+1)'(3);
        else if ({1'b0, r_width} > (CFG_W+1)'(W_LIM)) w_eff = (CFG_W+1)'(W_LIM);
        h_eff = {1'b0, r_height};
        if (r_height < CFG_W'(3)) h_eff = (CFG_W+1)'(3);
        else if ({1'b0, r_height} > (CFG_W+1)'(MAX_HEIGHT)) h_eff = (CFG_W+1)'(MAX_HEIGHT);
    end

    // ---- stage 0: accept, count position, read line stores ----
    logic             acc;
    logic [CFG_W:0]   r_col, r_row;
    logic [$clog2(QD):0] q_cnt;
    logic [CFG_W:0]   cur_c, cur_r;
    logic cfg_kind;

    assign cfg_kind = i_cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT
                      || i_cfg_index == REG_MODE);
    assign o_ready = (q_cnt <= ($clog2(QD)+1)'(QLIM));
    assign acc = i_valid && o_ready;
    assign cur_c = (r_col >= w_eff) ? '0 : r_col;
    assign cur_r = (r_row >= h_eff) ? '0 : r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_kind) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (cur_c + 1'b1 >= w_eff) begin
                r_col <= '0;
                r_row <= (cur_r + 1'b1 >= h_eff) ? '0 : cur_r + 1'b1;
            end else begin
                r_col <= cur_c + 1'b1;
                r_row <= cur_r;
            end
        end
    end

    // stage-1 registers
    logic             r1_v;
    t_pix             r1_pix;
    logic [CFG_W:0]   r1_c, r1_r;
    logic             r1_cend, r1_rend;
    t_pix             old_q, new_q;
    t_pix             pix_in;

    assign pix_in = {i_pix_red, i_pix_green, i_pix_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= acc;
        end
        if (acc) begin
            r1_pix <= pix_in;
            r1_c <= cur_c;
            r1_r <= cur_r;
            r1_cend <= (cur_c + 1'b1 == w_eff);
            r1_rend <= (cur_r + 1'b1 == h_eff);
        end
    end

    // line stores: written in the cycle after the read; a same-column
    // read-then-write never collides since the next read is a different column
    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_old (
        .i_clk(i_clk), .i_we(r1_v), .i_waddr(r1_c[AW-1:0]), .i_wdata(new_q),
        .i_re(acc), .i_raddr(cur_c[AW-1:0]), .o_rdata(old_q)
    );
    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_new (
        .i_clk(i_clk), .i_we(r1_v), .i_waddr(r1_c[AW-1:0]), .i_wdata(r1_pix),
        .i_re(acc), .i_raddr(cur_c[AW-1:0]), .o_rdata(new_q)
    );

    // ---- stage 1: shift the window, launch the median lanes ----
    t_pix r_win [6];
    t_pix [8:0] taps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else if (r1_v) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= old_q;
            r_win[4] <= new_q;
            r_win[5] <= r1_pix;
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) taps[k] = r_win[k];
        taps[6] = old_q;
        taps[7] = new_q;
        taps[8] = r1_pix;
    end

    t_chan [8:0] lane_in [3];
    t_chan       lane_med [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++)
            for (int t = 0; t < 9; t++)
                lane_in[ch][t] = taps[t][ch*CH_W +: CH_W];
    end

    // one lane per colour channel
    for (genvar g = 0; g < 3; g++) begin : g_lane
        mf3_lane u_lane (
            .i_clk(i_clk), .i_en(1'b1), .i_taps(lane_in[g]), .o_med(lane_med[g])
        );
    end

    // stage-2 and stage-3 side data, in step with the lanes
    typedef struct packed {
        logic v, cend, rend, tc;
        logic [CFG_W:0] c, r;
        t_pix pix, nw, centre;
    } t_side;
    t_side n_s1, r_s2, r_s3;

    always_comb begin
        n_s1.v = r1_v;
        n_s1.cend = r1_cend;
        n_s1.rend = r1_rend;
        n_s1.tc = r_tc;
        n_s1.c = r1_c;
        n_s1.r = r1_r;
        n_s1.pix = r1_pix;
        n_s1.nw = new_q;
        n_s1.centre = r_win[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s2 <= n_s1;
            r_s3 <= r_s2;
        end
    end

    // ---- stage 3: merge lanes, build up to three results ----
    t_res d0, d1, d2, e0, e1, e2;
    logic [2:0] push;
    logic a_en, b_en, c_en;
    t_pix med_pix;
    logic [CRD_W-1:0] cm1, c11, rm1, r11;

    assign med_pix = {r_s3.tc ? lane_med[2] : r_s3.centre[2*CH_W +: CH_W],
                      r_s3.tc ? lane_med[1] : r_s3.centre[CH_W +: CH_W],
                      lane_med[0]};
    assign c11 = r_s3.c[CRD_W-1:0];
    assign r11 = r_s3.r[CRD_W-1:0];
    assign cm1 = c11 - 1'b1;
    assign rm1 = r11 - 1'b1;

    always_comb begin
        a_en = 1'b0; b_en = 1'b0; c_en = 1'b0;
        e0 = '0; e1 = '0; e2 = '0;
        if (r_s3.r == '0) begin
            a_en = 1'b1;
            e0 = '{pix: r_s3.pix, col: c11, row: '0, filt: 1'b0, last: 1'b0};
        end else if (r_s3.r >= (CFG_W+1)'(2)) begin
            a_en = (r_s3.c >= (CFG_W+1)'(1));
            if (r_s3.c >= (CFG_W+1)'(2))
                e0 = '{pix: med_pix, col: cm1, row: rm1, filt: 1'b1, last: 1'b0};
            else
                e0 = '{pix: r_s3.centre, col: cm1, row: rm1, filt: 1'b0, last: 1'b0};
            b_en = r_s3.cend;
            e1 = '{pix: r_s3.nw, col: c11, row: rm1, filt: 1'b0, last: 1'b0};
            c_en = r_s3.rend;
            e2 = '{pix: r_s3.pix, col: c11, row: r11, filt: 1'b0, last: 1'b0};
        end
        if (!r_s3.v) begin
            a_en = 1'b0; b_en = 1'b0; c_en = 1'b0;
        end
        e2.last = 1'b1;
        e1.last = !c_en;
        e0.last = !b_en && !c_en;
        // pack enabled results into the low slots
        d0 = a_en ? e0 : (b_en ? e1 : e2);
        d1 = (a_en && b_en) ? e1 : e2;
        d2 = e2;
        push = 3'b000;
        case (2'(a_en) + 2'(b_en) + 2'(c_en))
            2'd1: push = 3'b001;
            2'd2: push = 3'b011;
            2'd3: push = 3'b111;
            default: push = 3'b000;
        endcase
    end

    t_res q;
    mf3_outq #(.DEPTH(QD)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push),
        .i_d0(d0), .i_d1(d1), .i_d2(d2),
        .o_valid(o_valid), .i_ready(i_ready), .o_q(q), .o_count(q_cnt)
    );

    assign o_out_blue = q.pix[0 +: CHANNEL_BITS];
    assign o_out_green = q.pix[CH_W +: CHANNEL_BITS];
    assign o_out_red = q.pix[2*CH_W +: CHANNEL_BITS];
    assign o_out_col = q.col;
    assign o_out_row = q.row;
    assign o_was_filtered = q.filt;
    assign o_last_of_run = q.last;
endmodule

FILE: sv/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks for the 3x3 median filter core.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_stream_core_assert.svh"
module mf3_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic [10:0] o_out_col,
    input logic o_was_filtered,
    input logic o_last_of_run
);
    // a held result keeps its coordinates and flags
    `MF_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        $stable({o_out_col, o_was_filtered, o_last_of_run}))
    // a held result stays offered
    `MF_ASSERT_NXT(a_vhold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // a median result never sits in column zero
    `MF_ASSERT_IMP(a_filt_col, i_clk, i_rst_n, o_valid && o_was_filtered,
        o_out_col != 11'd0)
    // no result appears right after reset
    `MF_ASSERT_NXT(a_rst, i_clk, 1'b1, !i_rst_n, !o_valid)
    // the empty queue takes items right after reset
    `MF_ASSERT_NXT(a_rdy, i_clk, 1'b1, !i_rst_n, o_ready)
endmodule

bind median_filter_3x3_stream_core mf3_checker u_mf3_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_out_col(o_out_col),
    .o_was_filtered(o_was_filtered), .o_last_of_run(o_last_of_run)
);

FILE: bench/median_filter_3x3_stream_core_checker.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_core_checker
// Watches the pixel, result and register ports of the median filter core,
// predicts every result pixel and compares the results in order.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_core_checker
    import mf3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_chan             i_blue,
    input  t_chan             i_green,
    input  t_chan             i_red,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_chan             i_out_blue,
    input  t_chan             i_out_green,
    input  t_chan             i_out_red,
    input  logic [CRD_W-1:0]  i_out_col,
    input  logic [CRD_W-1:0]  i_out_row,
    input  logic              i_out_filt,
    input  logic              i_out_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_items,
    output int                o_results,
    output int                o_filtered
);
    timeunit 1ns;
    timeprecision 1ps;

    // own copy of the filter state
    t_pix             line_two_back [MAX_WIDTH_DEF];
    t_pix             line_one_back [MAX_WIDTH_DEF];
    t_pix             win [6];
    int               pos_col;
    int               pos_row;
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic             cfg_true_colour;
    t_res             expected_pixels [$];

    initial begin
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            line_two_back[i] = '0;
            line_one_back[i] = '0;
        end
        o_fail_count = 0;
        o_items = 0;
        o_results = 0;
        o_filtered = 0;
    end

    assign o_pending = expected_pixels.size();

    function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // median of channel k over nine packed pixels
    function automatic t_chan median_of_nine(logic [9*PIX_W-1:0] taps, int k);
        t_chan v [9];
        t_chan x;
        int j;
        for (int i = 0; i < 9; i++) begin
            x = taps[i*PIX_W + k*CH_W +: CH_W];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[MID_TAP];
    endfunction

    function automatic t_res make_res(t_pix p, int c, int r, logic f);
        t_res e;
        e.pix = p;
        e.col = c[CRD_W-1:0];
        e.row = r[CRD_W-1:0];
        e.filt = f;
        e.last = 1'b0;
        return e;
    endfunction

    task automatic predict_pixel(t_pix pix);
        int w, h, c, r;
        t_pix above2, above1, res;
        t_res outs [$];
        logic [9*PIX_W-1:0] taps;
        w = clamp_size(cfg_width, MAX_WIDTH_DEF);
        h = clamp_size(cfg_height, MAX_HEIGHT);
        c = (pos_col >= w) ? 0 : pos_col;
        r = (pos_row >= h) ? 0 : pos_row;
        above2 = line_two_back[c];
        above1 = line_one_back[c];
        if (r == 0) begin
            outs.push_back(make_res(pix, c, 0, 1'b0));
        end else if (r >= 2) begin
            if (c >= 2) begin
                taps = {pix, above1, above2, win[5], win[4], win[3],
                        win[2], win[1], win[0]};
                res[CH_W-1:0] = median_of_nine(taps, 0);
                if (cfg_true_colour) begin
                    res[2*CH_W-1:CH_W] = median_of_nine(taps, 1);
                    res[3*CH_W-1:2*CH_W] = median_of_nine(taps, 2);
                end else begin
                    res[3*CH_W-1:CH_W] = win[4][3*CH_W-1:CH_W];
                end
                outs.push_back(make_res(res, c - 1, r - 1, 1'b1));
            end else if (c == 1) begin
                outs.push_back(make_res(win[4], 0, r - 1, 1'b0));
            end
            if (c == w - 1) outs.push_back(make_res(above1, c, r - 1, 1'b0));
            if (r == h - 1) outs.push_back(make_res(pix, c, r, 1'b0));
        end
        // shift the window left by one column
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = above2;
        win[4] = above1;
        win[5] = pix;
        line_two_back[c] = above1;
        line_one_back[c] = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_col = c;
        pos_row = r;
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) expected_pixels.push_back(outs[i]);
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name,
                     exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            foreach (win[i]) win[i] = '0;
            pos_col = 0;
            pos_row = 0;
            cfg_width = 12'd640;
            cfg_height = 12'd480;
            cfg_true_colour = 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH: cfg_width = i_cfg_data;
                    REG_HEIGHT: cfg_height = i_cfg_data;
                    REG_MODE: cfg_true_colour = i_cfg_data[0];
                    default: ;
                endcase
                // a write to the width, height or mode register restarts the frame
                if (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT
                        || i_cfg_index == REG_MODE) begin
                    pos_col = 0;
                    pos_row = 0;
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_pixel({i_red, i_green, i_blue});
                o_items++;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t unexpected result: actual col %0d row %0d",
                             $time, i_out_col, i_out_row);
                    o_fail_count++;
                end else begin
                    e = expected_pixels.pop_front();
                    check_field("blue", e.pix[CH_W-1:0], i_out_blue);
                    check_field("green", e.pix[2*CH_W-1:CH_W], i_out_green);
                    check_field("red", e.pix[3*CH_W-1:2*CH_W], i_out_red);
                    check_field("col", e.col, i_out_col);
                    check_field("row", e.row, i_out_row);
                    check_field("filtered", e.filt, i_out_filt);
                    check_field("last", e.last, i_out_last);
                end
                o_results++;
                if (i_out_filt) o_filtered++;
            end
        end
    end
endmodule

FILE: bench/median_filter_3x3_stream_core_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_core_tb
// Drives pixel frames of several sizes and both colour modes into the
// median filter core under varied back-pressure; a checker module predicts
// and compares every result pixel.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mf3_pkg::*;

    localparam int IDLE_LIMIT = 5000;   // cycles with no item moving
    localparam int DRAIN_WAIT = 10;     // above the core's output latency
    localparam int LONG_HOLD = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_chan i_pix_blue, i_pix_green, i_pix_red;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic o_valid;
    logic i_ready;
    t_chan o_out_blue, o_out_green, o_out_red;
    logic [CRD_W-1:0] o_out_col, o_out_row;
    logic o_was_filtered, o_last_of_run;

    int fail_count, pending, items, results, filtered;
    int tx_gap_pct, rx_stall_pct;
    bit hold_go;
    int hold_left;
    int idle_cycles;
    int frames_set;

    median_filter_3x3_stream_core dut (.*);

    median_filter_3x3_stream_core_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_blue(i_pix_blue), .i_green(i_pix_green), .i_red(i_pix_red),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_out_blue(o_out_blue), .i_out_green(o_out_green), .i_out_red(o_out_red),
        .i_out_col(o_out_col), .i_out_row(o_out_row),
        .i_out_filt(o_was_filtered), .i_out_last(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending), .o_items(items),
        .o_results(results), .o_filtered(filtered)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result side: stall at random, or hold off for a long stretch on request
    // so that the core's output queue fills and it stops taking pixels.
    always @(negedge i_clk) begin
        if (hold_go && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run if nothing has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one pixel, with random gaps before it; hold it until accepted.
    task automatic send_pixel(t_chan b, t_chan g, t_chan r);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pix_blue = b;
        i_pix_green = g;
        i_pix_red = r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_pixels(int n);
        for (int i = 0; i < n; i++)
            send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_all();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic tc);
        drain_all();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MODE, {{(CFG_W-1){1'b0}}, tc});
        frames_set++;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pix_blue = '0;
        i_pix_green = '0;
        i_pix_red = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        i_ready = 1'b0;
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        hold_go = 1'b0;
        hold_left = 0;
        idle_cycles = 0;
        frames_set = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // smallest frame, true colour: extremes round the centre pixel
        set_frame(12'd3, 12'd3, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h80, 8'h7F, 8'h01);
        send_pixel(8'h01, 8'hFE, 8'h80);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h55, 8'hAA, 8'h0F);
        // palette mode, run past the frame end so the counts wrap
        set_frame(12'd3, 12'd3, 1'b0);
        for (int i = 0; i < 11; i++)
            send_pixel(8'(i * 29), 8'(255 - i * 23), 8'(i * 101));
        // out-of-range registers saturate: width 0 gives 3, height 4095 gives 2048
        set_frame(12'd0, 12'd4095, 1'b0);
        send_random_pixels(15);

        // pause until every result is out, then start the widest frame
        set_frame(12'd4095, 12'd0, 1'b1);
        send_random_pixels(40);

        // random small frames through each idling phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 46; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_gap_pct = 16; rx_stall_pct = 16; end
            endcase
            for (int f = 0; f < 3; f++) begin
                set_frame(12'($urandom_range(3, 10)), 12'($urandom_range(3, 7)),
                          1'($urandom_range(1)));
                // hold the receiver off while pixels keep coming
                if (ph == 0 && f == 1) hold_go = 1'b1;
                send_random_pixels($urandom_range(15, 25));
            end
        end

        drain_all();
        $display("covered %0d pixels in %0d frame settings, %0d results (%0d medians)",
                 items, frames_set, results, filtered);
        $display("sizes 3x3 to 2048 wide, both colour modes, saturated registers, stalls");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
